>>> design/utf8_byte_stream_decoder_top_assert.svh
// Assertion macros for the UTF-8 decoder checker.
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define UBSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubsd check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define UBSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubsd check failed");

`endif

>>> design/ubsd_pkg.sv
`default_nettype none

package ubsd_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD2_SEL  = 8'hE0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD3_SEL  = 8'hF0;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] LEAD4_SEL  = 8'hF8;
  localparam logic [7:0] ASCII_LIM  = 8'h80;

  localparam logic [2:0] FOLLOW_STRAY = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            run_last;
  } out_item_t;

  typedef enum logic {
    CMD_COMBINE,
    CMD_SCAN
  } cmd_op_t;

  // CMD_COMBINE: bytes[0] lead, len = following byte count (1..3).
  // CMD_SCAN: len bytes (1..2) decoded as leads: a lone byte or an ended tail.
  typedef struct packed {
    cmd_op_t         op;
    logic [1:0]      len;
    logic [3:0][7:0] bytes;
  } cmd_t;

  function automatic logic [2:0] follow_len(input logic [7:0] c);
    logic [2:0] n;
    if (c < ASCII_LIM) begin
      n = 3'd0;
    end else if ((c & LEAD2_SEL) == LEAD2_TAG) begin
      n = 3'd1;
    end else if ((c & LEAD3_SEL) == LEAD3_TAG) begin
      n = 3'd2;
    end else if ((c & LEAD4_SEL) == LEAD4_TAG) begin
      n = 3'd3;
    end else begin
      n = FOLLOW_STRAY;
    end
    return n;
  endfunction

  function automatic logic [CP_W-1:0] combine(input logic [3:0][7:0] b,
                                              input logic [1:0]      n);
    logic [CP_W-1:0] cp;
    case (n)
      2'd1:    cp = {10'b0, b[0][4:0], b[1][5:0]};
      2'd2:    cp = {5'b0, b[0][3:0], b[1][5:0], b[2][5:0]};
      default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    endcase
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] ascii_cp(input logic [7:0] c);
    logic [CP_W-1:0] cp;
    if (follow_len(c) == 3'd0) begin
      cp = {13'b0, c};
    end else begin
      cp = '0;
    end
    return cp;
  endfunction

endpackage

`default_nettype wire

>>> design/ubsd_front.sv
`default_nettype none

module ubsd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ubsd_pkg::in_item_t data,
  output logic                   full,
  output logic                   cmd_push,
  output ubsd_pkg::cmd_t         cmd,
  input  wire logic              cmd_full
);

  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [1:0] held_count_next;

  logic            accept;
  logic            hold_we;
  logic            push_c;
  logic [7:0]      c;
  logic [2:0]      nc;
  logic [2:0]      nh;
  logic [3:0][7:0] comb_bytes;

  assign full   = cmd_full;
  assign accept = push & ~cmd_full;
  assign c      = data.text_byte;
  assign nc     = ubsd_pkg::follow_len(c);
  assign nh     = ubsd_pkg::follow_len(held_bytes[0]);

  always_comb begin
    comb_bytes[0] = held_bytes[0];
    comb_bytes[1] = (held_count == 2'd1) ? c : held_bytes[1];
    comb_bytes[2] = (held_count == 2'd2) ? c : held_bytes[2];
    comb_bytes[3] = c;
  end

  always_comb begin
    held_count_next = held_count;
    hold_we         = 1'b0;
    push_c          = 1'b0;
    cmd.op          = ubsd_pkg::CMD_SCAN;
    cmd.len         = 2'd1;
    cmd.bytes       = {4{c}};
    if (held_count == 2'd0) begin
      if (nc == 3'd0) begin
        push_c = 1'b1;
      end else if (!data.string_end && nc != ubsd_pkg::FOLLOW_STRAY) begin
        hold_we         = 1'b1;
        held_count_next = 2'd1;
      end
    end else if ({1'b0, held_count} == nh) begin
      push_c          = 1'b1;
      cmd.op          = ubsd_pkg::CMD_COMBINE;
      cmd.len         = held_count;
      cmd.bytes       = comb_bytes;
      held_count_next = 2'd0;
    end else if (data.string_end) begin
      // lead dropped; the rest is decoded again as an ended string
      push_c          = 1'b1;
      held_count_next = 2'd0;
      if (held_count == 2'd2) begin
        cmd.len      = 2'd2;
        cmd.bytes[0] = held_bytes[1];
        cmd.bytes[1] = c;
      end
    end else begin
      hold_we         = 1'b1;
      held_count_next = held_count + 2'd1;
    end
  end

  assign cmd_push = accept & push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
    if (accept && hold_we) begin
      held_bytes[held_count] <= c;
    end
  end

endmodule

`default_nettype wire

>>> design/ubsd_cmd_queue.sv
`default_nettype none

module ubsd_cmd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ubsd_pkg::cmd_t cmd_in,
  output logic                full,
  input  wire logic           pop,
  output ubsd_pkg::cmd_t      cmd_out,
  output logic                empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ubsd_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign cmd_out = mem[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= next_ptr(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
    if (do_push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> design/ubsd_back.sv
`default_nettype none

module ubsd_back #(
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_empty,
  input  wire ubsd_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                empty,
  input  wire logic           pop,
  output ubsd_pkg::out_item_t result
);

  localparam int unsigned PW = $clog2(RES_DEPTH);
  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  ubsd_pkg::out_item_t       mem [RES_DEPTH];
  logic [PW-1:0]             wr_ptr;
  logic [PW-1:0]             rd_ptr;
  logic [CW-1:0]             count;

  logic [ubsd_pkg::CP_W-1:0] v0;
  logic [ubsd_pkg::CP_W-1:0] v1;
  logic [2:0]                nx;
  logic                      has0;
  logic                      has1;
  logic [1:0]                k;
  logic                      take;
  logic                      deq;
  ubsd_pkg::out_item_t       r0;
  ubsd_pkg::out_item_t       r1;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(RES_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign nx = ubsd_pkg::follow_len(cmd.bytes[0]);

  always_comb begin
    v0 = '0;
    v1 = '0;
    unique case (cmd.op)
      ubsd_pkg::CMD_COMBINE: begin
        v0 = ubsd_pkg::combine(cmd.bytes, cmd.len);
      end
      ubsd_pkg::CMD_SCAN: begin
        if (cmd.len == 2'd1) begin
          v0 = ubsd_pkg::ascii_cp(cmd.bytes[0]);
        end else if (nx == 3'd0) begin
          v0 = ubsd_pkg::ascii_cp(cmd.bytes[0]);
          v1 = ubsd_pkg::ascii_cp(cmd.bytes[1]);
        end else if (nx == 3'd1) begin
          v0 = ubsd_pkg::combine(cmd.bytes, 2'd1);
        end else begin
          // lead cannot complete in a two-byte tail
          v1 = ubsd_pkg::ascii_cp(cmd.bytes[1]);
        end
      end
      default: begin
        v0 = '0;
      end
    endcase
  end

  assign has0 = (v0 != '0);
  assign has1 = (v1 != '0);
  assign k    = {1'b0, has0} + {1'b0, has1};

  always_comb begin
    r0.code_point = has0 ? v0 : v1;
    r0.run_last   = ~(has0 & has1);
    r1.code_point = v1;
    r1.run_last   = 1'b1;
  end

  assign take    = ~cmd_empty & (count <= CW'(RES_DEPTH - 2));
  assign cmd_pop = take;
  assign deq     = pop & ~empty;
  assign empty   = (count == '0);
  assign result  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take && k == 2'd1) begin
        wr_ptr <= next_ptr(wr_ptr);
      end else if (take && k == 2'd2) begin
        wr_ptr <= next_ptr(next_ptr(wr_ptr));
      end
      if (deq) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
      count <= count + (take ? CW'(k) : '0) - CW'(deq);
    end
    if (take && k != 2'd0) begin
      mem[wr_ptr] <= r0;
    end
    if (take && k == 2'd2) begin
      mem[next_ptr(wr_ptr)] <= r1;
    end
  end

endmodule

`default_nettype wire

>>> design/utf8_byte_stream_decoder_top.sv
// UTF-8 byte decoder: takes one byte per cycle while full is low, with a
// string-end flag, and delivers nonzero code points through a result queue
// (empty/pop), each after its command passes the command queue. Stray
// bytes and zero values produce nothing. A byte ending a string inside an
// open sequence can release two results (run_last marks the last); popped,
// they leave one per cycle through the result queue's single read port, so
// the sustained rate is one byte per cycle and full only rises when results
// are not popped and the command queue between the front and back fills.
`default_nettype none

module utf8_byte_stream_decoder_top #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ubsd_pkg::in_item_t data,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output ubsd_pkg::out_item_t     result
);

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_pop;
  logic           cmd_empty;
  ubsd_pkg::cmd_t cmd_in;
  ubsd_pkg::cmd_t cmd_head;

  ubsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .data     (data),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  ubsd_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .cmd_in  (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .cmd_out (cmd_head),
    .empty   (cmd_empty)
  );

  ubsd_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> design/ubsd_checker.sv
`default_nettype none

`include "utf8_byte_stream_decoder_top_assert.svh"

module ubsd_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire ubsd_pkg::out_item_t result
);

  `UBSD_ASSERT_NOW(a_reset_idle, $past(rst), empty && !full)

  `UBSD_ASSERT_NOW(a_nonzero, !empty, result.code_point != '0)

  // only an ended two-byte tail of two ASCII bytes gives a pair
  `UBSD_ASSERT_NOW(a_pair_ascii, !empty && !result.run_last, result.code_point[20:7] == '0)

  `UBSD_ASSERT_NEXT(a_pair_tail, pop && !empty && !result.run_last, !empty && result.run_last)

  `UBSD_ASSERT_NEXT(a_head_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind utf8_byte_stream_decoder_top ubsd_checker u_checker (.*);

`default_nettype wire
